[hw/rtl/clil_pkg.sv]
// Shared types and constants of the interpolating colormap lookup.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package clil_pkg;

  localparam int unsigned DefaultTableDepth = 16;

  localparam int unsigned SampleW   = 24;
  localparam int unsigned InvSpanW  = 32;
  localparam int unsigned CountW    = 5;
  localparam int unsigned EntryIdxW = 4;
  localparam int unsigned ChanW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FracW     = 16;
  localparam int unsigned UnitW     = FracW + 1;
  localparam int unsigned ProdW     = SampleW + InvSpanW - FracW;
  localparam int unsigned BlendW    = ChanW + UnitW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [UnitW-1:0] UnitOne = {1'b1, {FracW{1'b0}}};

  localparam logic OpWrite = 1'b1;

  localparam logic [CfgIdxW-1:0] RegMinValue   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInvSpan    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegEntryCount = 2'd2;

  localparam logic [SampleW-1:0]  ResetMinValue   = '0;
  localparam logic [InvSpanW-1:0] ResetInvSpan    = 32'd256;
  localparam logic [CountW-1:0]   ResetEntryCount = 5'd1;

  // alpha in the top 16 bits, red in the bottom 16
  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } entry_t;

  // load enables of the five pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

[hw/rtl/clil_norm.sv]
// Normalise stages: offset, reciprocal-span multiply, clamp and scale to table index.
// Depends on clil_pkg; feeds clil_table with read/write addresses.
`timescale 1ns / 1ps

module clil_norm #(
  parameter int unsigned TableDepth = clil_pkg::DefaultTableDepth,
  localparam int unsigned IdxW = $clog2(TableDepth)
) (
  input  logic                              clk_i,
  input  clil_pkg::stage_en_t               en_i,
  input  logic                              opcode_i,
  input  logic signed [clil_pkg::SampleW-1:0]  sample_i,
  input  logic [clil_pkg::EntryIdxW-1:0]    entry_index_i,
  input  clil_pkg::entry_t                  entry_i,
  input  logic signed [clil_pkg::SampleW-1:0]  min_value_i,
  input  logic [clil_pkg::InvSpanW-1:0]     inv_span_i,
  input  logic [clil_pkg::CountW-1:0]       entry_count_i,
  output logic                              wr_o,
  output logic [clil_pkg::EntryIdxW-1:0]    waddr_o,
  output clil_pkg::entry_t                  wdata_o,
  output logic [IdxW-1:0]                   raddr0_o,
  output logic [IdxW-1:0]                   raddr1_o,
  output logic [clil_pkg::FracW-1:0]        frac_o
);
  import clil_pkg::*;

  logic [SampleW:0]          diff;
  logic [SampleW+InvSpanW-1:0] prod_full;

  logic                 wr1_q, wr2_q;
  logic                 pos1_q;
  logic [SampleW-1:0]   d1_q;
  logic [EntryIdxW-1:0] widx1_q, widx2_q;
  entry_t               ent1_q, ent2_q;
  logic [ProdW-1:0]     prod2_q;

  logic [UnitW-1:0]      unit_pos;
  logic [IdxW-1:0]       nm1;
  logic [UnitW+IdxW-1:0] scaled;
  logic [IdxW:0]         idx;
  logic                  last;

  assign diff = {sample_i[SampleW-1], sample_i} - {min_value_i[SampleW-1], min_value_i};
  assign prod_full = {{InvSpanW{1'b0}}, d1_q} * {{SampleW{1'b0}}, inv_span_i};

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      wr1_q   <= (opcode_i == OpWrite);
      pos1_q  <= !diff[SampleW] && (diff != '0);
      d1_q    <= diff[SampleW-1:0];
      widx1_q <= entry_index_i;
      ent1_q  <= entry_i;
    end
    if (en_i.s2) begin
      wr2_q   <= wr1_q;
      widx2_q <= widx1_q;
      ent2_q  <= ent1_q;
      prod2_q <= pos1_q ? prod_full[SampleW+InvSpanW-1:FracW] : '0;
    end
  end

  assign unit_pos = (prod2_q > ProdW'(UnitOne)) ? UnitOne : prod2_q[UnitW-1:0];

  always_comb begin
    if (entry_count_i == '0) begin
      nm1 = '0;
    end else if (32'(entry_count_i) >= TableDepth) begin
      nm1 = IdxW'(TableDepth - 1);
    end else begin
      nm1 = IdxW'(entry_count_i - CountW'(1));
    end
  end

  assign scaled = {{IdxW{1'b0}}, unit_pos} * {{UnitW{1'b0}}, nm1};
  assign idx    = scaled[UnitW+IdxW-1:FracW];
  assign last   = (idx >= {1'b0, nm1});

  // top of the range: last entry alone, zero weight on the neighbour
  assign raddr0_o = last ? nm1 : idx[IdxW-1:0];
  assign raddr1_o = last ? nm1 : idx[IdxW-1:0] + IdxW'(1);
  assign frac_o   = last ? '0 : scaled[FracW-1:0];

  assign wr_o    = wr2_q;
  assign waddr_o = widx2_q;
  assign wdata_o = ent2_q;

endmodule

[hw/rtl/clil_table.sv]
// Colour table: one write port, two registered read ports.
// Depends on clil_pkg for the entry type.
`timescale 1ns / 1ps

module clil_table #(
  parameter int unsigned TableDepth = clil_pkg::DefaultTableDepth,
  localparam int unsigned IdxW = $clog2(TableDepth)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [clil_pkg::EntryIdxW-1:0] waddr_i,
  input  clil_pkg::entry_t               wdata_i,
  input  logic                           re_i,
  input  logic [IdxW-1:0]                raddr0_i,
  input  logic [IdxW-1:0]                raddr1_i,
  output clil_pkg::entry_t               rdata0_o,
  output clil_pkg::entry_t               rdata1_o
);
  import clil_pkg::*;

  entry_t mem [TableDepth];
  entry_t rd0_q, rd1_q;
  logic   wr_hit;

  // indexes past the table are dropped
  assign wr_hit = we_i && (32'(waddr_i) < TableDepth);

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem[IdxW'(waddr_i)] <= wdata_i;
    end
    if (re_i) begin
      rd0_q <= mem[raddr0_i];
      rd1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

[hw/rtl/clil_blend.sv]
// Blend stages: linear interpolation of two entries and byte conversion.
// Depends on clil_pkg; takes read data from clil_table.
`timescale 1ns / 1ps

module clil_blend (
  input  logic                            clk_i,
  input  clil_pkg::stage_en_t             en_i,
  input  logic [clil_pkg::FracW-1:0]      frac_i,
  input  clil_pkg::entry_t                rdata0_i,
  input  clil_pkg::entry_t                rdata1_i,
  output logic [3:0][clil_pkg::ByteW-1:0] bytes_o
);
  import clil_pkg::*;

  logic [FracW-1:0]           frac3_q;
  logic [UnitW-1:0]           w0;
  logic [3:0][ChanW-1:0]      c0, c1;
  logic [3:0][BlendW-1:0]     p0, p1, blend_d;
  logic [3:0][BlendW-1:0]     blend4_q;
  logic [3:0][BlendW+ByteW-1:0] prod255;
  logic [3:0][ByteW+1:0]      hi;
  logic [3:0][ByteW-1:0]      byte_d, bytes5_q;

  assign c0 = rdata0_i;
  assign c1 = rdata1_i;
  assign w0 = UnitOne - {1'b0, frac3_q};

  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      p0[ch] = {{UnitW{1'b0}}, c0[ch]} * {{ChanW{1'b0}}, w0};
      p1[ch] = {{UnitW{1'b0}}, c1[ch]} * {{(ChanW + 1){1'b0}}, frac3_q};
      blend_d[ch] = p0[ch] + p1[ch];
    end
  end

  // v * 255 >> 31, saturated
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      prod255[ch] = {blend4_q[ch], {ByteW{1'b0}}} - {{ByteW{1'b0}}, blend4_q[ch]};
      hi[ch]      = prod255[ch][BlendW+ByteW-1:31];
      byte_d[ch]  = (hi[ch][ByteW+1:ByteW] != '0) ? {ByteW{1'b1}} : hi[ch][ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      frac3_q <= frac_i;
    end
    if (en_i.s4) begin
      blend4_q <= blend_d;
    end
    if (en_i.s5) begin
      bytes5_q <= byte_d;
    end
  end

  assign bytes_o = bytes5_q;

endmodule

[hw/rtl/colormap_interpolating_lookup_unit.sv]
// Interpolating colormap lookup: maps a signed 24-bit sample to an RGBA byte colour.
// Top level; depends on clil_pkg, clil_norm, clil_table and clil_blend.
// Input channel (in_valid_i / in_stall_o): a beat with opcode map carries a sample and
// yields one output beat; a beat with opcode write loads one table entry and yields none.
// Output channel (out_valid_o / out_stall_i): four colour bytes per beat.
// Five register stages: offset, span multiply, clamp/scale with table read, blend,
// byte conversion; a map beat passes through them in that order to reach the output.
// One beat is taken every cycle while the output is not stalled; the rate is set by
// the pipeline, each stage moving whenever the stage after it is empty or moving on.
// Writes land in the table at the read stage, so any later sample sees them.
// The user writes configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) only while the
// block is idle; the block does not enforce it. Reset empties the pipeline and restores
// min_value 0, inv_span 256, entry_count 1; table contents are undefined until written.
// A stalled output holds its beat; bubbles behind it fill, then in_stall_o rises.
`timescale 1ns / 1ps

module colormap_interpolating_lookup_unit #(
  parameter int unsigned TableDepth = clil_pkg::DefaultTableDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [clil_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [clil_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic signed [clil_pkg::SampleW-1:0] sample_i,
  input  logic [clil_pkg::EntryIdxW-1:0]    entry_index_i,
  input  logic [clil_pkg::ChanW-1:0]        entry_red_i,
  input  logic [clil_pkg::ChanW-1:0]        entry_green_i,
  input  logic [clil_pkg::ChanW-1:0]        entry_blue_i,
  input  logic [clil_pkg::ChanW-1:0]        entry_alpha_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [clil_pkg::ByteW-1:0]        red_byte_o,
  output logic [clil_pkg::ByteW-1:0]        green_byte_o,
  output logic [clil_pkg::ByteW-1:0]        blue_byte_o,
  output logic [clil_pkg::ByteW-1:0]        alpha_byte_o
);
  import clil_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);

  logic [SampleW-1:0]  min_value_q;
  logic [InvSpanW-1:0] inv_span_q;
  logic [CountW-1:0]   entry_count_q;

  logic [4:0] stg_vld_q;
  logic [4:0] stg_vld_d;
  logic [4:0] rdy;
  stage_en_t  en;

  entry_t               in_entry;
  logic                 wr2;
  logic [EntryIdxW-1:0] waddr;
  entry_t               wdata;
  logic [IdxW-1:0]      raddr0, raddr1;
  logic [FracW-1:0]     frac;
  entry_t               rdata0, rdata1;
  logic                 tbl_we;
  logic [3:0][ByteW-1:0] bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_value_q   <= ResetMinValue;
      inv_span_q    <= ResetInvSpan;
      entry_count_q <= ResetEntryCount;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMinValue:   min_value_q   <= cfg_wdata_i[SampleW-1:0];
        RegInvSpan:    inv_span_q    <= cfg_wdata_i[InvSpanW-1:0];
        RegEntryCount: entry_count_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[4] = !stg_vld_q[4] || !out_stall_i;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !stg_vld_q[k] || rdy[k+1];
    end
  end

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];
  assign en.s5 = rdy[4];

  // write beats leave the pipe once they reach the table
  assign stg_vld_d[0] = in_valid_i;
  assign stg_vld_d[1] = stg_vld_q[0];
  assign stg_vld_d[2] = stg_vld_q[1] && !wr2;
  assign stg_vld_d[3] = stg_vld_q[2];
  assign stg_vld_d[4] = stg_vld_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= '0;
    end else begin
      for (int k = 0; k < 5; k++) begin
        if (rdy[k]) begin
          stg_vld_q[k] <= stg_vld_d[k];
        end
      end
    end
  end

  assign tbl_we = stg_vld_q[1] && wr2 && rdy[2];

  assign in_entry.red   = entry_red_i;
  assign in_entry.green = entry_green_i;
  assign in_entry.blue  = entry_blue_i;
  assign in_entry.alpha = entry_alpha_i;

  clil_norm #(
    .TableDepth(TableDepth)
  ) u_norm (
    .clk_i        (clk_i),
    .en_i         (en),
    .opcode_i     (opcode_i),
    .sample_i     (sample_i),
    .entry_index_i(entry_index_i),
    .entry_i      (in_entry),
    .min_value_i  (min_value_q),
    .inv_span_i   (inv_span_q),
    .entry_count_i(entry_count_q),
    .wr_o         (wr2),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .raddr0_o     (raddr0),
    .raddr1_o     (raddr1),
    .frac_o       (frac)
  );

  clil_table #(
    .TableDepth(TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (en.s3),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(rdata0),
    .rdata1_o(rdata1)
  );

  clil_blend u_blend (
    .clk_i   (clk_i),
    .en_i    (en),
    .frac_i  (frac),
    .rdata0_i(rdata0),
    .rdata1_i(rdata1),
    .bytes_o (bytes)
  );

  assign in_stall_o   = !rdy[0];
  assign out_valid_o  = stg_vld_q[4];
  assign red_byte_o   = bytes[0];
  assign green_byte_o = bytes[1];
  assign blue_byte_o  = bytes[2];
  assign alpha_byte_o = bytes[3];

`ifndef SYNTHESIS
  // input only backs up when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (stg_vld_q == '1))
    else $error("input stalled with a free stage");

  // a stalled output beat holds the blend stage behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_vld_q[4] && stg_vld_q[3] && out_stall_i) |=> stg_vld_q[3])
    else $error("blend stage dropped under stall");

  // a table write never becomes an output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |=> !stg_vld_q[2])
    else $error("write beat entered the read stage");
`endif

endmodule

[bench/tb_colormap_interpolating_lookup_unit.sv]
// Self-checking bench for colormap_interpolating_lookup_unit: directed rows, then random phases.
// Keeps its own colour table and registers to predict every output beat.
// Depends on clil_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_colormap_interpolating_lookup_unit;
  import clil_pkg::*;

  localparam logic OpMap = ~OpWrite;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned BeatsPerPhase = 48;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned Depth = DefaultTableDepth;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic                 op;
    logic [SampleW-1:0]   smp;
    logic [EntryIdxW-1:0] idx;
    entry_t               color;
  } beat_t;

  typedef enum logic {RowBeat, RowReg} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CfgIdxW-1:0]   reg_idx;
    logic [CfgDataW-1:0]  reg_val;
    beat_t                beat;
    bit                   typed;
    rgba_t                want;
  } row_t;

  // entry 0 and entry 2 of the directed part, as bytes
  localparam rgba_t FirstColor = '{red: 8'd255, green: 8'd0, blue: 8'd255, alpha: 8'd127};
  localparam rgba_t LastColor  = '{red: 8'd255, green: 8'd255, blue: 8'd0, alpha: 8'd255};
  localparam rgba_t NoColor    = '0;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  beat_t               in_beat = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rgba_t               out_color;

  logic [63:0]         shadow_lut [Depth];
  logic [SampleW-1:0]  cur_min = ResetMinValue;
  logic [InvSpanW-1:0] cur_inv = ResetInvSpan;
  logic [CountW-1:0]   cur_count = ResetEntryCount;
  rgba_t               pending_colors [$];
  row_t                steps [$];

  int unsigned errors = 0;
  int unsigned stuck = 0;
  int unsigned n_maps = 0;
  int unsigned n_writes = 0;
  int unsigned n_reg_writes = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  colormap_interpolating_lookup_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (in_beat.op),
    .sample_i     (in_beat.smp),
    .entry_index_i(in_beat.idx),
    .entry_red_i  (in_beat.color.red),
    .entry_green_i(in_beat.color.green),
    .entry_blue_i (in_beat.color.blue),
    .entry_alpha_i(in_beat.color.alpha),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_byte_o   (out_color.red),
    .green_byte_o (out_color.green),
    .blue_byte_o  (out_color.blue),
    .alpha_byte_o (out_color.alpha)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic rgba_t predict_color(logic [SampleW-1:0] smp);
    longint            offs;
    longint unsigned   pos, scaled, n, seg, frac, c_lo, c_hi, acc;
    logic [63:0]       lo, hi;
    logic [ByteW-1:0]  b [4];
    n = cur_count;
    if (n < 1) n = 1;
    if (n > Depth) n = Depth;
    offs = longint'($signed(smp)) - longint'($signed(cur_min));
    if (offs <= 0) begin
      pos = 0;
    end else begin
      pos = (longint'(offs) * longint'({32'b0, cur_inv})) >> FracW;
      if (pos > 65536) pos = 65536;
    end
    scaled = pos * (n - 1);
    seg = scaled >> FracW;
    frac = scaled & 64'hFFFF;
    // at the top the last entry stands alone: same sum with a zero fraction
    if (seg >= n - 1) begin
      lo = shadow_lut[n - 1];
      hi = lo;
      frac = 0;
    end else begin
      lo = shadow_lut[seg];
      hi = shadow_lut[seg + 1];
    end
    for (int ch = 0; ch < 4; ch++) begin
      c_lo = lo[16*ch +: 16];
      c_hi = hi[16*ch +: 16];
      acc = ((c_lo * (65536 - frac) + c_hi * frac) * 255) >> 31;
      b[ch] = (acc > 255) ? 8'd255 : acc[7:0];
    end
    return '{red: b[0], green: b[1], blue: b[2], alpha: b[3]};
  endfunction

  function automatic entry_t rand_entry();
    logic [ChanW-1:0] c [4];
    for (int ch = 0; ch < 4; ch++) begin
      if ($urandom_range(0, 3) == 0) c[ch] = ChanW'($urandom_range(0, 65535));
      else c[ch] = ChanW'($urandom_range(0, 32768));
    end
    return '{alpha: c[3], blue: c[2], green: c[1], red: c[0]};
  endfunction

  function automatic row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    row_t r;
    r.kind = RowReg;
    r.reg_idx = idx;
    r.reg_val = val;
    r.beat = '0;
    r.typed = 1'b0;
    r.want = NoColor;
    return r;
  endfunction

  function automatic row_t map_row(logic [SampleW-1:0] smp, bit typed, rgba_t want);
    row_t r;
    r.kind = RowBeat;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.beat = '0;
    r.beat.op = OpMap;
    r.beat.smp = smp;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t write_row(logic [EntryIdxW-1:0] idx, logic [ChanW-1:0] red,
                                     logic [ChanW-1:0] green, logic [ChanW-1:0] blue,
                                     logic [ChanW-1:0] alpha);
    row_t r;
    r.kind = RowBeat;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.beat = '0;
    r.beat.op = OpWrite;
    r.beat.idx = idx;
    r.beat.color = '{alpha: alpha, blue: blue, green: green, red: red};
    r.typed = 1'b0;
    r.want = NoColor;
    return r;
  endfunction

  function automatic void add_step(row_t r);
    steps.insert(steps.size(), r);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegMinValue:   cur_min = val[SampleW-1:0];
      RegInvSpan:    cur_inv = val[InvSpanW-1:0];
      RegEntryCount: cur_count = val[CountW-1:0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // table writes yield no beat, so give the pipeline time past the last colour
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_beat(beat_t b, bit typed, rgba_t want);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    if (b.op == OpWrite) begin
      shadow_lut[b.idx] = b.color;
      n_writes++;
    end else begin
      pending_colors.insert(pending_colors.size(), typed ? want : predict_color(b.smp));
      n_maps++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);
      end
    end
  end

  initial begin
    rgba_t want;
    forever begin
      @(negedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
      if (rst_ni && out_valid && !out_stall) begin
        if (pending_colors.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("colour beat with nothing predicted: r%0d g%0d b%0d a%0d",
                     out_color.red, out_color.green, out_color.blue, out_color.alpha);
        end else begin
          want = pending_colors.pop_front();
          if (out_color !== want) begin
            errors++;
            if (errors <= MaxReports)
              $display("colour mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                       want.red, want.green, want.blue, want.alpha,
                       out_color.red, out_color.green, out_color.blue, out_color.alpha);
          end
        end
      end
    end
  end

  initial begin
    wait (stuck >= IdleLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    beat_t               b;
    logic [31:0]         rnd;
    longint unsigned     span, recip;
    logic [SampleW-1:0]  min_pick;
    logic [CountW-1:0]   count_pick;

    for (int e = 0; e < Depth; e++) shadow_lut[e] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_step(write_row(4'd0, 16'd32768, 16'd0, 16'd65535, 16'd16384));
    add_step(map_row(24'h7FFFFF, 1'b1, FirstColor));
    add_step(map_row(24'h800000, 1'b1, FirstColor));
    add_step(write_row(4'd1, 16'd0, 16'd32768, 16'd32768, 16'd0));
    add_step(write_row(4'd2, 16'd65535, 16'd65535, 16'd0, 16'd32768));
    add_step(reg_row(RegEntryCount, 32'd3));
    add_step(map_row(24'h000000, 1'b1, FirstColor));
    add_step(map_row(24'hFFFFFF, 1'b1, FirstColor));
    add_step(map_row(24'h7FFFFF, 1'b0, NoColor));
    add_step(reg_row(RegInvSpan, 32'd512));
    add_step(map_row(24'h400000, 1'b0, NoColor));
    add_step(map_row(24'h200000, 1'b0, NoColor));
    add_step(reg_row(RegMinValue, 32'h0080_0000));
    add_step(reg_row(RegInvSpan, 32'hFFFF_FFFF));
    add_step(map_row(24'h7FFFFF, 1'b1, LastColor));
    add_step(map_row(24'h800000, 1'b1, FirstColor));
    add_step(map_row(24'h800001, 1'b0, NoColor));
    add_step(reg_row(RegInvSpan, 32'd0));
    add_step(map_row(24'h7FFFFF, 1'b1, FirstColor));
    add_step(reg_row(RegEntryCount, 32'd0));
    add_step(reg_row(RegInvSpan, 32'hFFFF_FFFF));
    add_step(map_row(24'h7FFFFF, 1'b1, FirstColor));
    // count beyond the table with zero span: only the first pair is touched
    add_step(reg_row(RegEntryCount, 32'd31));
    add_step(reg_row(RegInvSpan, 32'd0));
    add_step(map_row(24'h01E240, 1'b1, FirstColor));
    add_step(reg_row(RegMinValue, 32'h007F_FFFF));
    add_step(reg_row(RegInvSpan, 32'd256));
    add_step(reg_row(RegEntryCount, 32'd3));
    add_step(map_row(24'h7FFFFF, 1'b1, FirstColor));
    add_step(map_row(24'h800000, 1'b1, FirstColor));

    foreach (steps[k]) begin
      if (steps[k].kind == RowReg) begin
        drain();
        write_reg(steps[k].reg_idx, steps[k].reg_val);
      end else begin
        send_beat(steps[k].beat, steps[k].typed, steps[k].want);
      end
    end

    // whole table written before any setting can reach past entry 2
    for (int e = 0; e < Depth; e++) begin
      b = '0;
      b.op = OpWrite;
      b.idx = EntryIdxW'(e);
      b.color = rand_entry();
      send_beat(b, 1'b0, NoColor);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      rnd = $urandom;
      min_pick = rnd[SampleW-1:0];
      span = $urandom_range(1, 1 << $urandom_range(1, 24));
      count_pick = CountW'($urandom_range(1, Depth));
      case (p)
        0: count_pick = 5'd16;
        1: begin
          count_pick = 5'd1;
          min_pick = 24'h800000;
          span = 1;
        end
        2: begin
          count_pick = 5'd2;
          span = 0;
        end
        4: begin
          count_pick = 5'd31;
          min_pick = 24'h7FFFFF;
        end
        5: count_pick = 5'd0;
        7: begin
          count_pick = 5'd16;
          min_pick = 24'h800000;
          span = 24'hFFFFFF;
        end
        default: ;
      endcase
      recip = (span == 0) ? 0 : (64'h1_0000_0000 / span);
      if (recip > 64'hFFFF_FFFF) recip = 64'hFFFF_FFFF;
      write_reg(RegMinValue, {8'h00, min_pick});
      write_reg(RegInvSpan, recip[31:0]);
      write_reg(RegEntryCount, {27'b0, count_pick});
      quiet = (p == 6);
      for (int k = 0; k < BeatsPerPhase; k++) begin
        if (p == 3 && k == 12) hold_req = 1'b1;
        b = '0;
        if ($urandom_range(0, 99) < 15) begin
          b.op = OpWrite;
          b.idx = EntryIdxW'($urandom_range(0, Depth - 1));
          b.color = rand_entry();
        end else begin
          b.op = OpMap;
          if (span == 0 || $urandom_range(0, 99) < 30) rnd = $urandom;
          else rnd = 32'(min_pick) + $urandom_range(0, 32'(span));
          b.smp = rnd[SampleW-1:0];
        end
        send_beat(b, 1'b0, NoColor);
      end
      quiet = 1'b0;
    end

    drain();
    $display("Mapped %0d samples and loaded %0d entries over %0d register writes, %0d mismatches.",
             n_maps, n_writes, n_reg_writes, errors);
    $display("Settings took in zero and full span, counts 0, 1, 16 and 31, and both sample ends.");
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/clil_pkg.sv
hw/rtl/clil_norm.sv
hw/rtl/clil_table.sv
hw/rtl/clil_blend.sv
hw/rtl/colormap_interpolating_lookup_unit.sv
bench/tb_colormap_interpolating_lookup_unit.sv
